// ----- rtl/b58enc_pkg.sv -----
// Package for the base58 block encoder: state type, sizes and lookup functions.
// Used by b58enc_div and base58_block_encoder_unit; depends on nothing else.
package b58enc_pkg;

    localparam int unsigned RADIX      = 58;
    localparam int unsigned FULL_BLOCK = 8;
    localparam int unsigned MAX_CHARS  = 11;

    // Base58 alphabet, first character in the top byte
    localparam logic [RADIX*8-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } b58enc_state_t;

    // Map a digit value to its ASCII character
    function automatic logic [6:0] digit_char(input logic [5:0] digit);
        logic [5:0] pos;
        logic [8:0] base;
        pos  = 6'(RADIX - 1) - digit;
        base = {pos, 3'b000};
        return ALPHABET[base +: 7];
    endfunction

    // Encoded length for a block size; zero for empty or oversized blocks
    function automatic logic [3:0] block_len(input logic [3:0] size);
        logic [3:0] len;
        case (size)
            4'd1:    len = 4'd2;
            4'd2:    len = 4'd3;
            4'd3:    len = 4'd5;
            4'd4:    len = 4'd6;
            4'd5:    len = 4'd7;
            4'd6:    len = 4'd9;
            4'd7:    len = 4'd10;
            4'd8:    len = 4'd11;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/b58enc_div.sv -----
// Shared divide-by-58 unit: one byte of the dividend per use, eight restoring steps.
// Depends on b58enc_pkg for the radix.
module b58enc_div
    import b58enc_pkg::*;
(
    input  logic [5:0] rem_in,
    input  logic [7:0] dividend_byte,
    output logic [7:0] quot_byte,
    output logic [5:0] rem_out
);

    // Shift in one dividend bit per step, subtract the radix when it fits
    always_comb
    begin
        logic [6:0] partial;
        logic [5:0] rem_work;
        rem_work  = rem_in;
        quot_byte = '0;
        for (int i = 7; i >= 0; i--)
        begin
            partial = {rem_work, dividend_byte[i]};
            if (partial >= 7'(RADIX))
            begin
                partial      = partial - 7'(RADIX);
                quot_byte[i] = 1'b1;
            end
            rem_work = partial[5:0];
        end
        rem_out = rem_work;
    end

endmodule

// ----- rtl/base58_block_encoder_unit.sv -----
// Base58 block encoder: one block of up to 8 bytes in, up to 11 characters out.
// The shared divide unit works through all eight bytes of the number for each digit,
// and the first character is output only after every digit of the block is computed.
// Throughput: then one character per cycle while the output does not stall; the next
// block is taken only after the last character of the previous one is loaded for output.
// Empty or oversized blocks are accepted and give no output; reset (rst_n,
// asynchronous, active low) clears the sequencer and output valid.
module base58_block_encoder_unit
    import b58enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_value,
    input  logic [3:0]  block_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic        last_char
);

    b58enc_state_t state_reg, state_next;

    logic [63:0] num_reg, num_next;
    logic [5:0]  rem_reg, rem_next;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  wr_idx_reg, wr_idx_next;
    logic [3:0]  rd_idx_reg, rd_idx_next;
    logic [3:0]  len_reg, len_next;
    logic [5:0]  digit_reg [MAX_CHARS];

    logic        out_valid_reg, out_valid_next;
    logic [6:0]  out_char_reg, out_char_next;
    logic        last_reg, last_next;

    logic [7:0]  quot_byte;
    logic [5:0]  div_rem;
    logic        accept;
    logic        digit_done;
    logic        out_load;
    logic        emit_last;
    logic [3:0]  in_len;
    logic [63:0] masked_value;

    b58enc_div u_div (
        .rem_in        (rem_reg),
        .dividend_byte (num_reg[63:56]),
        .quot_byte     (quot_byte),
        .rem_out       (div_rem)
    );

    assign in_len     = block_len(block_size);
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign digit_done = (state_reg == ST_DIV) && (step_reg == 3'(FULL_BLOCK - 1));
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_last  = (rd_idx_reg == len_reg - 4'd1);

    // Drop the bytes above the block size
    always_comb
    begin
        for (int b = 0; b < FULL_BLOCK; b++)
        begin
            masked_value[b*8 +: 8] = (4'(b) < block_size) ? block_value[b*8 +: 8] : 8'h00;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_len != 4'd0))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (digit_done && (wr_idx_reg == 4'd0))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register next values
    always_comb
    begin
        num_next       = num_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        len_next       = len_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        // Load a new item
        if (accept)
        begin
            num_next    = masked_value;
            rem_next    = '0;
            step_next   = '0;
            len_next    = in_len;
            wr_idx_next = in_len - 4'd1;
            rd_idx_next = '0;
        end

        // Advance the division by one byte
        if (state_reg == ST_DIV)
        begin
            num_next  = {num_reg[55:0], quot_byte};
            rem_next  = div_rem;
            step_next = step_reg + 3'd1;
            if (digit_done)
            begin
                rem_next    = '0;
                wr_idx_next = wr_idx_reg - 4'd1;
            end
        end

        // Hand the next character to the output register
        if (out_load)
        begin
            out_char_next  = digit_char(digit_reg[rd_idx_reg]);
            last_next      = emit_last;
            out_valid_next = 1'b1;
            rd_idx_next    = rd_idx_reg + 4'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        wr_idx_reg   <= wr_idx_next;
        rd_idx_reg   <= rd_idx_next;
        len_reg      <= len_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    // Digit buffer, filled least significant digit last position first
    always_ff @(posedge clk)
    begin
        if (digit_done)
        begin
            digit_reg[wr_idx_reg] <= div_rem;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

endmodule
